[src/rrt_pkg.sv]
package rrt_pkg;

  // limits on array element count and bulk string length
  localparam int MAX_TOKEN_LEN = 65536;
  localparam int MAX_ELEMENTS  = 255;

  localparam int NUM_MAX = (MAX_TOKEN_LEN > MAX_ELEMENTS) ? MAX_TOKEN_LEN : MAX_ELEMENTS;
  localparam int NUM_W   = $clog2(NUM_MAX + 1);
  localparam int EL_W    = $clog2(MAX_ELEMENTS + 1);
  localparam int MUL_W   = NUM_W + 4;

  localparam int TOK_W   = 8;
  localparam logic [TOK_W-1:0] TOK_MAX = '1;

  // result slots per request byte and queue depth
  localparam int SLOTS   = 3;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);

  // characters
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // end of message status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNC     = 2'd1;
  localparam logic [1:0] ST_BAD_COUNT = 2'd2;
  localparam logic [1:0] ST_BAD_LEN   = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data;
    logic             tlast;
    logic [TOK_W-1:0] count;
    logic [1:0]       status;
  } slot_t;

  // results caused by one request byte, slot 0 first
  typedef struct packed {
    slot_t [SLOTS-1:0] slot;
    logic  [1:0]       n;
  } bundle_t;

endpackage

[src/resp_request_tokenizer.sv]
// request tokenizer: takes one request byte per cycle (msg_last on the final byte)
// and streams token bytes, empty-token marks and one end-of-message result per
// request message carrying the token count and status. a message opening with
// '*' is read as an array of '$'-prefixed length-counted strings, anything else
// is split on whitespace. each byte is parsed in the cycle it is accepted; its
// results (up to three) go into a four-entry queue and the back end sends them
// one per cycle while out_stall is low, so input runs at one byte per cycle when
// results drain at least as fast as made; in_stall rises only when queue fills.
module resp_request_tokenizer (
  input  logic       clk,
  input  logic       rst,
  // request byte channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       msg_last,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] out_byte,
  output logic       token_last,
  output logic [rrt_pkg::TOK_W-1:0] token_count,
  output logic [1:0] status
);
  import rrt_pkg::*;

  // front to queue
  logic    push;
  bundle_t push_data;
  logic    full;

  // queue to back
  bundle_t head;
  logic    empty;
  logic    pop;

  // front: parse state machine, one request byte per accepted cycle
  rrt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .msg_last  (msg_last),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  // bundles of results waiting for the back end
  rrt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  // back: walks the head bundle one result per cycle while out_stall is low
  rrt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .out_byte    (out_byte),
    .token_last  (token_last),
    .token_count (token_count),
    .status      (status)
  );

endmodule

[src/rrt_front.sv]
module rrt_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_byte,
  input  logic             msg_last,
  output logic             push,
  output rrt_pkg::bundle_t push_data,
  input  logic             full
);
  import rrt_pkg::*;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_INLINE  = 3'd1;
  localparam logic [2:0] PH_COUNT   = 3'd2;
  localparam logic [2:0] PH_DOLLAR  = 3'd3;
  localparam logic [2:0] PH_LEN     = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_SKIP    = 3'd6;
  localparam logic [2:0] PH_DONE    = 3'd7;

  logic [2:0]       phase, phase_next;
  logic [NUM_W-1:0] acc, acc_next;
  logic [EL_W-1:0]  elements_left, elements_left_next;
  logic [NUM_W-1:0] payload_left, payload_left_next;
  logic [1:0]       skip_left, skip_left_next;
  logic [7:0]       held_byte, held_byte_next;
  logic             held_valid, held_valid_next;
  logic [TOK_W-1:0] tokens_done, tokens_done_next;
  logic [1:0]       error_code, error_code_next;
  logic             saw_cr, saw_cr_next;
  logic             digit_seen, digit_seen_next;

  logic             accept;
  logic             is_ws, is_digit, over;
  logic [MUL_W-1:0] mul, cap;
  logic [NUM_W-1:0] sat;
  logic             count_inc, flush;
  logic [1:0]       nres, skip_dec;
  logic [EL_W-1:0]  el_dec;
  logic [1:0]       st;
  logic [1:0]       bad_code;
  bundle_t          bun;

  assign accept   = in_valid && !in_stall;
  assign in_stall = full;

  // decimal digit step, saturated at the field's limit
  assign is_ws    = in_byte inside {CH_SP, [CH_TAB:CH_CR]};
  assign is_digit = in_byte inside {[CH_ZERO:CH_NINE]};
  assign mul      = MUL_W'({acc, 3'b000}) + MUL_W'({acc, 1'b0}) + MUL_W'(in_byte[3:0]);
  assign cap      = (phase == PH_COUNT) ? MUL_W'(MAX_ELEMENTS) : MUL_W'(MAX_TOKEN_LEN);
  assign over     = mul > cap;
  assign sat      = over ? cap[NUM_W-1:0] : mul[NUM_W-1:0];
  assign bad_code = (phase == PH_COUNT) ? ST_BAD_COUNT : ST_BAD_LEN;

  always_comb begin
    phase_next         = phase;
    acc_next           = acc;
    elements_left_next = elements_left;
    payload_left_next  = payload_left;
    skip_left_next     = skip_left;
    held_byte_next     = held_byte;
    held_valid_next    = held_valid;
    tokens_done_next   = tokens_done;
    error_code_next    = error_code;
    saw_cr_next        = saw_cr;
    digit_seen_next    = digit_seen;
    bun                = '0;
    nres               = 2'd0;
    count_inc          = 1'b0;
    flush              = 1'b0;
    st                 = ST_OK;
    skip_dec           = (skip_left != 2'd0) ? skip_left - 2'd1 : skip_left;
    el_dec             = (elements_left != '0) ? elements_left - EL_W'(1) : elements_left;

    if ((phase == PH_IDLE && in_byte != CH_STAR) || phase == PH_INLINE) begin
      phase_next = PH_INLINE;
      if (is_ws) begin
        if (held_valid) begin
          bun.slot[nres] = '{kind: KIND_BYTE, data: held_byte, tlast: 1'b1,
                             count: '0, status: ST_OK};
          nres            = nres + 2'd1;
          count_inc       = 1'b1;
          held_valid_next = 1'b0;
        end
      end else begin
        if (held_valid) begin
          bun.slot[nres] = '{kind: KIND_BYTE, data: held_byte, tlast: 1'b0,
                             count: '0, status: ST_OK};
          nres = nres + 2'd1;
        end
        held_byte_next  = in_byte;
        held_valid_next = 1'b1;
      end
    end else begin
      case (phase)
        PH_IDLE: begin
          phase_next      = PH_COUNT;
          acc_next        = '0;
          saw_cr_next     = 1'b0;
          digit_seen_next = 1'b0;
        end
        PH_COUNT, PH_LEN: begin
          if (saw_cr) begin
            if (in_byte == CH_LF && digit_seen) begin
              if (phase == PH_COUNT) begin
                elements_left_next = acc[EL_W-1:0];
                phase_next = (acc == '0) ? PH_DONE : PH_DOLLAR;
              end else if (acc == '0) begin
                bun.slot[nres] = '{kind: KIND_EMPTY, data: 8'd0, tlast: 1'b1,
                                   count: '0, status: ST_OK};
                nres           = nres + 2'd1;
                count_inc      = 1'b1;
                skip_left_next = 2'd2;
                phase_next     = PH_SKIP;
              end else begin
                payload_left_next = acc;
                phase_next        = PH_PAYLOAD;
              end
            end else begin
              if (error_code == ST_OK) error_code_next = bad_code;
              phase_next = PH_DONE;
            end
          end else if (in_byte == CH_CR) begin
            saw_cr_next = 1'b1;
          end else if (is_digit) begin
            acc_next        = sat;
            digit_seen_next = 1'b1;
            if (over && error_code == ST_OK) error_code_next = bad_code;
          end else begin
            if (error_code == ST_OK) error_code_next = bad_code;
            phase_next = PH_DONE;
          end
        end
        PH_DOLLAR: begin
          if (in_byte == CH_DOLLAR) begin
            phase_next      = PH_LEN;
            acc_next        = '0;
            saw_cr_next     = 1'b0;
            digit_seen_next = 1'b0;
          end else begin
            phase_next = PH_DONE;
          end
        end
        PH_PAYLOAD: begin
          if (payload_left <= NUM_W'(1)) begin
            bun.slot[nres] = '{kind: KIND_BYTE, data: in_byte, tlast: 1'b1,
                               count: '0, status: ST_OK};
            nres              = nres + 2'd1;
            count_inc         = 1'b1;
            payload_left_next = '0;
            skip_left_next    = 2'd2;
            phase_next        = PH_SKIP;
          end else begin
            bun.slot[nres] = '{kind: KIND_BYTE, data: in_byte, tlast: 1'b0,
                               count: '0, status: ST_OK};
            nres              = nres + 2'd1;
            payload_left_next = payload_left - NUM_W'(1);
          end
        end
        PH_SKIP: begin
          skip_left_next = skip_dec;
          if (skip_dec == 2'd0) begin
            elements_left_next = el_dec;
            phase_next = (el_dec == '0) ? PH_DONE : PH_DOLLAR;
          end
        end
        default: begin
        end
      endcase
    end

    if (count_inc && tokens_done != TOK_MAX) tokens_done_next = tokens_done + TOK_W'(1);

    if (msg_last) begin
      // flush a held inline byte, then the end of message result
      flush = (phase_next == PH_INLINE) && held_valid_next;
      if (flush) begin
        bun.slot[nres] = '{kind: KIND_BYTE, data: held_byte_next, tlast: 1'b1,
                           count: '0, status: ST_OK};
        nres = nres + 2'd1;
        if (tokens_done_next != TOK_MAX) tokens_done_next = tokens_done_next + TOK_W'(1);
      end
      st = error_code_next;
      if (st == ST_OK && phase_next == PH_PAYLOAD && payload_left_next != '0) st = ST_TRUNC;
      bun.slot[nres] = '{kind: KIND_END, data: 8'd0, tlast: 1'b0,
                         count: tokens_done_next, status: st};
      nres = nres + 2'd1;

      phase_next         = PH_IDLE;
      acc_next           = '0;
      elements_left_next = '0;
      payload_left_next  = '0;
      skip_left_next     = 2'd0;
      held_byte_next     = 8'd0;
      held_valid_next    = 1'b0;
      tokens_done_next   = '0;
      error_code_next    = ST_OK;
      saw_cr_next        = 1'b0;
      digit_seen_next    = 1'b0;
    end
    bun.n = nres;
  end

  assign push      = accept && (bun.n != 2'd0);
  assign push_data = bun;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      acc           <= '0;
      elements_left <= '0;
      payload_left  <= '0;
      skip_left     <= 2'd0;
      held_byte     <= 8'd0;
      held_valid    <= 1'b0;
      tokens_done   <= '0;
      error_code    <= ST_OK;
      saw_cr        <= 1'b0;
      digit_seen    <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      acc           <= acc_next;
      elements_left <= elements_left_next;
      payload_left  <= payload_left_next;
      skip_left     <= skip_left_next;
      held_byte     <= held_byte_next;
      held_valid    <= held_valid_next;
      tokens_done   <= tokens_done_next;
      error_code    <= error_code_next;
      saw_cr        <= saw_cr_next;
      digit_seen    <= digit_seen_next;
    end
  end

  a_held_inline: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> phase == PH_INLINE)
    else $error("held byte outside inline phase");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> payload_left != '0)
    else $error("payload phase with no bytes left");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> skip_left != 2'd0)
    else $error("skip phase with nothing to skip");

  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    accept && msg_last |=> phase == PH_IDLE && tokens_done == '0)
    else $error("state not cleared after end of message");

endmodule

[src/rrt_queue.sv]
module rrt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rrt_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output rrt_pkg::bundle_t head,
  output logic             empty
);
  import rrt_pkg::*;

  bundle_t           entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   cnt;

  assign full  = cnt == (QPTR_W + 1)'(QDEPTH);
  assign empty = cnt == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop)      cnt <= cnt + (QPTR_W + 1)'(1);
      else if (pop && !push) cnt <= cnt - (QPTR_W + 1)'(1);
    end
  end

endmodule

[src/rrt_back.sv]
module rrt_back (
  input  logic             clk,
  input  logic             rst,
  input  rrt_pkg::bundle_t head,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       out_byte,
  output logic             token_last,
  output logic [rrt_pkg::TOK_W-1:0] token_count,
  output logic [1:0]       status
);
  import rrt_pkg::*;

  logic [1:0] idx;
  logic       take, at_end;
  slot_t      cur;

  assign cur       = head.slot[idx];
  assign out_valid = !empty;
  assign take      = out_valid && !out_stall;
  assign at_end    = idx == (head.n - 2'd1);
  assign pop       = take && at_end;

  assign kind        = cur.kind;
  assign out_byte    = cur.data;
  assign token_last  = cur.tlast;
  assign token_count = cur.count;
  assign status      = cur.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (take) begin
      idx <= at_end ? 2'd0 : idx + 2'd1;
    end
  end

endmodule
